FILE: design/uqp_pkg.sv
// uqp_pkg: shared types, codes and constants of the url query parser
// used by every module of the parser, depends on nothing
`default_nettype none

package uqp_pkg;

  // default buffer size in bytes
  localparam int unsigned MessageBytesDef = 256;
  // largest number of key=value pairs after '?'
  localparam logic [2:0] MaxKeys = 3'd5;
  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // characters that steer the parse
  localparam logic [7:0] ChQmark = 8'h3f;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  // 'A' - 10, takes an upper-case hex letter to its value
  localparam logic [7:0] HexAlphaOfs = 8'h37;

  // parse modes
  localparam logic [2:0] ModeFile     = 3'd0;
  localparam logic [2:0] ModeKey      = 3'd1;
  localparam logic [2:0] ModeValue    = 3'd2;
  localparam logic [2:0] ModeFileEsc1 = 3'd3;
  localparam logic [2:0] ModeFileEsc2 = 3'd4;
  localparam logic [2:0] ModeValEsc1  = 3'd5;
  localparam logic [2:0] ModeValEsc2  = 3'd6;

  // status codes
  localparam logic [2:0] StContinue   = 3'd0;
  localparam logic [2:0] StDone       = 3'd1;
  localparam logic [2:0] StBadKey     = 3'd2;
  localparam logic [2:0] StTooMany    = 3'd3;
  localparam logic [2:0] StBadEsc     = 3'd4;
  localparam logic [2:0] StOverflow   = 3'd5;
  localparam logic [2:0] StIncomplete = 3'd6;

  // field kinds
  localparam logic [1:0] KindFile  = 2'd0;
  localparam logic [1:0] KindKey   = 2'd1;
  localparam logic [1:0] KindValue = 2'd2;

  // classified input item as it waits in the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       is_term;   // nul or blank
    logic       is_blank;
    logic       is_qmark;
    logic       is_eq;
    logic       is_amp;
    logic       is_plus;
    logic       is_pct;
    logic       hex_ok;
    logic [3:0] hex;
    logic       start;
    logic       last;
  } uqp_cls_t;

  // one result item
  typedef struct packed {
    logic [2:0] status;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic [7:0] byte_position;
    logic [1:0] field_kind;
    logic [2:0] key_index;
  } uqp_res_t;

  // queue control driven by the front
  typedef struct packed {
    logic push;
  } uqp_qctl_t;

endpackage

`default_nettype wire

FILE: design/uqp_front.sv
// uqp_front: accepts raw path bytes and classifies each character
// depends on uqp_pkg
`default_nettype none

module uqp_front (
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,
  input  wire logic            s_axis_tlast,
  input  wire logic            s_axis_tuser,
  input  wire logic            q_full_i,
  output uqp_pkg::uqp_qctl_t   qctl_o,
  output uqp_pkg::uqp_cls_t    cls_o
);

  logic [7:0] ch;
  logic       is_digit;
  logic       is_upper_hex;

  assign ch = s_axis_tdata;

  // accept whenever the queue has room
  assign s_axis_tready = !q_full_i;
  assign qctl_o.push   = s_axis_tvalid && !q_full_i;

  // hex digit detection, digits and upper-case letters only
  assign is_digit     = (ch >= uqp_pkg::ChZero) && (ch <= uqp_pkg::ChNine);
  assign is_upper_hex = (ch >= uqp_pkg::ChUpA) && (ch <= uqp_pkg::ChUpF);

  // character classes
  always_comb begin
    cls_o.ch       = ch;
    cls_o.is_blank = (ch == uqp_pkg::ChSpace) || (ch == uqp_pkg::ChTab) ||
                     (ch == uqp_pkg::ChLf) || (ch == uqp_pkg::ChCr);
    cls_o.is_term  = cls_o.is_blank || (ch == uqp_pkg::ChNul);
    cls_o.is_qmark = (ch == uqp_pkg::ChQmark);
    cls_o.is_eq    = (ch == uqp_pkg::ChEq);
    cls_o.is_amp   = (ch == uqp_pkg::ChAmp);
    cls_o.is_plus  = (ch == uqp_pkg::ChPlus);
    cls_o.is_pct   = (ch == uqp_pkg::ChPct);
    cls_o.hex_ok   = is_digit || is_upper_hex;
    cls_o.hex      = is_digit ? ch[3:0] : 4'(ch - uqp_pkg::HexAlphaOfs);
    cls_o.start    = s_axis_tuser;
    cls_o.last     = s_axis_tlast;
  end

endmodule

`default_nettype wire

FILE: design/uqp_queue.sv
// uqp_queue: short queue of classified items between front and back
// depends on uqp_pkg
`default_nettype none

module uqp_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire uqp_pkg::uqp_qctl_t qctl_i,
  input  wire uqp_pkg::uqp_cls_t  cls_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    valid_o,
  output uqp_pkg::uqp_cls_t       cls_o
);

  localparam int unsigned Depth = uqp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  uqp_pkg::uqp_cls_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cls_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (qctl_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (qctl_i.push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!qctl_i.push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (qctl_i.push) begin
      mem_q[wr_ptr_q] <= cls_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count above depth");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !qctl_i.push)
    else $error("push into full queue");

  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qctl_i.push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("fill count lost a push");
`endif

endmodule

`default_nettype wire

FILE: design/uqp_back.sv
// uqp_back: parse state machine and output register of the url query parser
// depends on uqp_pkg
`default_nettype none

module uqp_back #(
  parameter int unsigned MessageBytes = uqp_pkg::MessageBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire uqp_pkg::uqp_cls_t cls_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output uqp_pkg::uqp_res_t      res_o
);

  localparam int unsigned CntW = $clog2(MessageBytes + 1);

  logic [2:0]      mode_q, mode_d;
  logic [3:0]      nib_q, nib_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      keys_q, keys_d;
  logic            halt_q, halt_d;
  logic            out_valid_q, out_valid_d;
  uqp_pkg::uqp_res_t out_q;

  // state as seen after an optional restart
  logic [2:0]      eff_mode;
  logic [3:0]      eff_nib;
  logic [CntW-1:0] eff_cnt;
  logic [2:0]      eff_keys;
  logic            eff_halt;

  logic            wr_en;
  logic [7:0]      wr_byte;
  logic [1:0]      wr_kind;
  logic [2:0]      st;
  logic [2:0]      st_fin;
  uqp_pkg::uqp_res_t res_d;

  // take an item when the output register is free or being drained
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // start flag restarts the parse before the byte
  assign eff_mode = cls_i.start ? uqp_pkg::ModeFile : mode_q;
  assign eff_nib  = cls_i.start ? 4'd0 : nib_q;
  assign eff_cnt  = cls_i.start ? '0 : cnt_q;
  assign eff_keys = cls_i.start ? 3'd0 : keys_q;
  assign eff_halt = cls_i.start ? 1'b0 : halt_q;

  // per-byte parse step
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'd0;
    wr_kind = uqp_pkg::KindFile;
    st      = uqp_pkg::StContinue;
    mode_d  = eff_mode;
    nib_d   = eff_nib;
    keys_d  = eff_keys;
    if (!eff_halt) begin
      case (eff_mode)
        uqp_pkg::ModeFile: begin
          if (cls_i.is_term) begin
            wr_en  = 1'b1;
            keys_d = 3'd0;
            st     = uqp_pkg::StDone;
          end else if (cls_i.is_qmark) begin
            wr_en  = 1'b1;
            keys_d = 3'd0;
            mode_d = uqp_pkg::ModeKey;
          end else if (cls_i.is_pct) begin
            mode_d = uqp_pkg::ModeFileEsc1;
          end else begin
            wr_en   = 1'b1;
            wr_byte = cls_i.ch;
          end
        end
        uqp_pkg::ModeKey: begin
          wr_kind = uqp_pkg::KindKey;
          if (cls_i.is_eq) begin
            wr_en  = 1'b1;
            keys_d = eff_keys + 3'd1;
            mode_d = uqp_pkg::ModeValue;
          end else if (cls_i.is_blank || cls_i.is_pct || cls_i.is_amp) begin
            st = uqp_pkg::StBadKey;
          end else begin
            wr_en   = 1'b1;
            wr_byte = cls_i.ch;
          end
        end
        uqp_pkg::ModeValue: begin
          wr_kind = uqp_pkg::KindValue;
          if (cls_i.is_term) begin
            wr_en = 1'b1;
            st    = uqp_pkg::StDone;
          end else if (cls_i.is_pct) begin
            mode_d = uqp_pkg::ModeValEsc1;
          end else if (cls_i.is_amp) begin
            wr_en = 1'b1;
            if (eff_keys < uqp_pkg::MaxKeys) begin
              mode_d = uqp_pkg::ModeKey;
            end else begin
              st = uqp_pkg::StTooMany;
            end
          end else if (cls_i.is_plus) begin
            wr_en   = 1'b1;
            wr_byte = uqp_pkg::ChSpace;
          end else begin
            wr_en   = 1'b1;
            wr_byte = cls_i.ch;
          end
        end
        uqp_pkg::ModeFileEsc1, uqp_pkg::ModeValEsc1: begin
          if (!cls_i.hex_ok) begin
            st = uqp_pkg::StBadEsc;
          end else begin
            nib_d  = cls_i.hex;
            mode_d = (eff_mode == uqp_pkg::ModeFileEsc1) ? uqp_pkg::ModeFileEsc2
                                                         : uqp_pkg::ModeValEsc2;
          end
        end
        uqp_pkg::ModeFileEsc2, uqp_pkg::ModeValEsc2: begin
          if (!cls_i.hex_ok) begin
            st = uqp_pkg::StBadEsc;
          end else begin
            wr_en   = 1'b1;
            wr_byte = {eff_nib, cls_i.hex};
            if (eff_mode == uqp_pkg::ModeFileEsc2) begin
              wr_kind = uqp_pkg::KindFile;
              mode_d  = uqp_pkg::ModeFile;
            end else begin
              wr_kind = uqp_pkg::KindValue;
              mode_d  = uqp_pkg::ModeValue;
            end
          end
        end
        default: begin
          mode_d = uqp_pkg::ModeFile;
        end
      endcase
    end
  end

  // buffer count, overflow, last-byte check and halting
  always_comb begin
    cnt_d  = eff_cnt + CntW'(wr_en);
    st_fin = st;
    if (st_fin == uqp_pkg::StContinue && !eff_halt &&
        cnt_d >= CntW'(MessageBytes)) begin
      st_fin = uqp_pkg::StOverflow;
    end
    if (st_fin == uqp_pkg::StContinue && !eff_halt && cls_i.last) begin
      st_fin = uqp_pkg::StIncomplete;
    end
    halt_d = eff_halt || (st_fin != uqp_pkg::StContinue);

    res_d.status        = st_fin;
    res_d.byte_valid    = wr_en;
    res_d.byte_out      = wr_en ? wr_byte : 8'd0;
    res_d.byte_position = wr_en ? 8'(eff_cnt) : 8'd0;
    res_d.field_kind    = wr_en ? wr_kind : uqp_pkg::KindFile;
    res_d.key_index     = wr_en ? eff_keys : 3'd0;
  end

  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  // parse state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= uqp_pkg::ModeFile;
      nib_q       <= 4'd0;
      cnt_q       <= '0;
      keys_q      <= 3'd0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        mode_q <= mode_d;
        nib_q  <= nib_d;
        cnt_q  <= cnt_d;
        keys_q <= keys_d;
        halt_q <= halt_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MessageBytes))
    else $error("write count beyond buffer size");

  a_keys_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    keys_q <= uqp_pkg::MaxKeys)
    else $error("key count beyond limit");

  a_halted_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && halt_q && !cls_i.start) |=>
      (out_q.status == uqp_pkg::StContinue && !out_q.byte_valid))
    else $error("halted parser produced output");

  a_mode_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= uqp_pkg::ModeValEsc2)
    else $error("parse mode out of range");
`endif

endmodule

`default_nettype wire

FILE: design/url_query_parser_unit.sv
// url_query_parser_unit: top level of the url query parser
// depends on uqp_pkg, uqp_front, uqp_queue and uqp_back
//
// usage:
//   input channel s_axis: one raw path character per item in tdata, tuser
//   set restarts the parse before that byte, tlast marks the last byte
//   output channel m_axis: exactly one result item per input item, in order;
//   tuser is set when the item carries a stored byte or terminator
// path: a byte is written into the queue, and its result is then registered in
//   the output register before it is offered
// throughput: one item per cycle while m_axis_tready is high; the parse step in
//   the back stage is combinational decode logic and the two-entry queue keeps
//   input taking bytes while a result waits
// reset: parse starts in the filename field with an empty buffer, the queue
//   and the output register are empty
// stall: when m_axis_tready is low the result holds, the queue fills and
//   s_axis_tready drops once it is full; nothing is lost or repeated
`default_nettype none

module url_query_parser_unit #(
  parameter int unsigned MessageBytes = uqp_pkg::MessageBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // byte_in
  input  wire logic        s_axis_tlast,  // message_last
  input  wire logic        s_axis_tuser,  // message_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], byte_out[10:3], byte_position[18:11], field_kind[20:19],
  // key_index[23:21]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tuser   // byte_valid
);

  uqp_pkg::uqp_qctl_t qctl;
  uqp_pkg::uqp_cls_t  cls_in;
  uqp_pkg::uqp_cls_t  cls_head;
  uqp_pkg::uqp_res_t  res;
  logic               q_full;
  logic               q_valid;
  logic               pop;

  // front: accept and classify
  uqp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .qctl_o        (qctl),
    .cls_o         (cls_in)
  );

  // queue between front and back
  uqp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qctl_i  (qctl),
    .cls_i   (cls_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cls_o   (cls_head)
  );

  // back: parse and register the result
  uqp_back #(
    .MessageBytes (MessageBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cls_i       (cls_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // pack result fields, key_index in the highest bits and status in the lowest
  assign m_axis_tdata = {res.key_index, res.field_kind, res.byte_position,
                         res.byte_out, res.status};
  assign m_axis_tuser = res.byte_valid;

endmodule

`default_nettype wire
